// ===== hw/rtl/tfn_pkg.sv =====
// tfn_pkg: shared constants, status codes and controller/datapath structs
// for the triangle flat normal unit. No dependencies.

package tfn_pkg;

    // fixed field widths
    localparam int COORD_BITS   = 16;
    localparam int CORNER_BITS  = 10;
    localparam int VERTEX_BITS  = 3 * COORD_BITS;
    localparam int CFG_BITS     = 32;
    localparam int OUT_BITS     = 16;

    localparam int VERTEX_DEPTH_DEFAULT = 1024;
    localparam logic [CFG_BITS-1:0] MIN_LEN_SQ_RESET = 32'd2814745;
    localparam logic [OUT_BITS-1:0] UNIT_Q14 = 16'd16384;

    // result status codes
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_STORED  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // arithmetic widths
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int CROSS_W    = 2 * EDGE_W + 1;
    localparam int MAG_W      = 2 * EDGE_W - 1;
    localparam int MUL_W      = MAG_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = PROD_W;
    localparam int RAD_W      = 96;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int FRAC_SHIFT = 28;
    localparam int NUM_W      = MAG_W + FRAC_SHIFT + 1;
    localparam int Q_W        = 17;
    localparam int DIV_STEPS  = Q_W;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int CROSS_PRODS = 6;
    localparam int STEP_W     = 6;

    // read port selector
    localparam logic [1:0] RD_A = 2'd0;
    localparam logic [1:0] RD_B = 2'd1;
    localparam logic [1:0] RD_C = 2'd2;

    typedef struct packed {
        logic              load_in;
        logic [1:0]        rd_sel;
        logic              ld_va;
        logic              ld_vb;
        logic              ld_vc;
        logic              edges;
        logic              mul_issue;
        logic              mul_acc;
        logic              take_abs;
        logic              sq_issue;
        logic              sq_acc;
        logic              degen_chk;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              emit;
        logic [1:0]        kind;
        logic [STEP_W-1:0] step;
    } tfn_cmd_t;

    typedef struct packed {
        logic is_face;
        logic in_range;
        logic store_full;
        logic degenerate;
        logic out_free;
    } tfn_sts_t;

endpackage

// ===== hw/rtl/triangle_flat_normal_unit.sv =====
// triangle_flat_normal_unit: top level of the flat face normal block
// depends on tfn_pkg, tfn_ctrl and tfn_datapath
//
//  channel  | direction | tdata (low bit up)                  | tuser
//  s_       | in        | x, y, z, corner a, b, c             | command
//  m_       | out       | normal x, y, z, normal index        | status
//  cfg_     | in        | min_length_squared write            | -
//
// a full face runs 48 root steps and 17 divide steps; the cross
// products and squares share one multiplier. a result held by
// m_tready low holds back the next result until it is taken.
// reset is synchronous, active low; the vertex store is not cleared.
// one request at a time; a finished result waits in the output register
// while the next request is taken.

module triangle_flat_normal_unit #(
    parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [79:0]                 s_tdata,  // x, y, z, a, b, c, zero pad
    input  logic                        s_tuser,  // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,  // nx, ny, nz, normal index
    output logic [1:0]                  m_tuser,  // status
    input  logic                        cfg_we,
    input  logic [tfn_pkg::CFG_BITS-1:0] cfg_wdata
);
    import tfn_pkg::*;

    tfn_cmd_t cmd;
    tfn_sts_t sts;
    logic [OUT_BITS-1:0] nx, ny, nz, idx;

    // sequencing
    tfn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and storage
    tfn_datapath #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_command (s_tuser),
        .in_vertex  (s_tdata[VERTEX_BITS-1:0]),
        .in_a       (s_tdata[VERTEX_BITS +: CORNER_BITS]),
        .in_b       (s_tdata[VERTEX_BITS+CORNER_BITS +: CORNER_BITS]),
        .in_c       (s_tdata[VERTEX_BITS+2*CORNER_BITS +: CORNER_BITS]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_nx     (nx),
        .out_ny     (ny),
        .out_nz     (nz),
        .out_index  (idx)
    );

    assign m_tdata = {idx, nz, ny, nx};

endmodule

// ===== hw/rtl/tfn_ctrl.sv =====
// tfn_ctrl: sequencing state machine of the triangle flat normal unit
// depends on tfn_pkg; drives tfn_datapath through command/status structs

module tfn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tfn_pkg::tfn_sts_t sts,
    output tfn_pkg::tfn_cmd_t cmd
);
    import tfn_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_LDC   = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_CROSS = 4'd7;
    localparam logic [3:0] S_ABS   = 4'd8;
    localparam logic [3:0] S_SQR   = 4'd9;
    localparam logic [3:0] S_DEGEN = 4'd10;
    localparam logic [3:0] S_ROOT  = 4'd11;
    localparam logic [3:0] S_DINIT = 4'd12;
    localparam logic [3:0] S_DIV   = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        kind_reg, kind_next;

    assign s_tready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            kind_reg  <= ST_NORMAL;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.kind   = kind_reg;
        cmd.rd_sel = RD_A;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.is_face) begin
                    if (sts.in_range) begin
                        state_next = S_RDA;
                    end else begin
                        kind_next  = ST_SKIPPED;
                        state_next = S_EMIT;
                    end
                end else begin
                    kind_next  = sts.store_full ? ST_FULL : ST_STORED;
                    state_next = S_EMIT;
                end
            end
            S_RDA: begin
                cmd.rd_sel = RD_A;
                state_next = S_RDB;
            end
            S_RDB: begin
                cmd.rd_sel = RD_B;
                cmd.ld_va  = 1'b1;
                state_next = S_RDC;
            end
            S_RDC: begin
                cmd.rd_sel = RD_C;
                cmd.ld_vb  = 1'b1;
                state_next = S_LDC;
            end
            S_LDC: begin
                cmd.ld_vc  = 1'b1;
                state_next = S_EDGE;
            end
            S_EDGE: begin
                cmd.edges  = 1'b1;
                step_next  = '0;
                state_next = S_CROSS;
            end
            // six products through the shared multiplier, each accumulated from the product register after issue
            S_CROSS: begin
                cmd.mul_issue = (step_reg < STEP_W'(CROSS_PRODS));
                cmd.mul_acc   = (step_reg != '0);
                if (step_reg == STEP_W'(CROSS_PRODS)) begin
                    state_next = S_ABS;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ABS: begin
                cmd.take_abs = 1'b1;
                step_next    = '0;
                state_next   = S_SQR;
            end
            S_SQR: begin
                cmd.sq_issue = (step_reg < STEP_W'(3));
                cmd.sq_acc   = (step_reg != '0);
                if (step_reg == STEP_W'(3)) begin
                    state_next = S_DEGEN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DEGEN: begin
                cmd.degen_chk = 1'b1;
                step_next     = '0;
                kind_next     = ST_NORMAL;
                state_next    = sts.degenerate ? S_EMIT : S_ROOT;
            end
            S_ROOT: begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = S_DINIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = S_EMIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tfn_datapath.sv =====
// tfn_datapath: vertex store, shared multiplier, bit-serial square root,
// three divider lanes and the output register; depends on tfn_pkg

module tfn_datapath #(
    parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tfn_pkg::tfn_cmd_t              cmd,
    output tfn_pkg::tfn_sts_t              sts,
    input  logic                           in_command,
    input  logic [tfn_pkg::VERTEX_BITS-1:0] in_vertex,
    input  logic [tfn_pkg::CORNER_BITS-1:0] in_a,
    input  logic [tfn_pkg::CORNER_BITS-1:0] in_b,
    input  logic [tfn_pkg::CORNER_BITS-1:0] in_c,
    input  logic                           cfg_we,
    input  logic [tfn_pkg::CFG_BITS-1:0]    cfg_wdata,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     out_status,
    output logic [tfn_pkg::OUT_BITS-1:0]    out_nx,
    output logic [tfn_pkg::OUT_BITS-1:0]    out_ny,
    output logic [tfn_pkg::OUT_BITS-1:0]    out_nz,
    output logic [tfn_pkg::OUT_BITS-1:0]    out_index
);
    import tfn_pkg::*;

    localparam int AW   = $clog2(VERTEX_DEPTH);
    localparam int VC_W = $clog2(VERTEX_DEPTH + 1);
    localparam int CMPW = (VC_W > CORNER_BITS) ? VC_W : CORNER_BITS;

    // captured request
    logic                   cmd_reg;
    logic [VERTEX_BITS-1:0] vin_reg;
    logic [CMPW-1:0]        ia_reg, ib_reg, ic_reg;
    logic [VC_W-1:0]        vcount_reg;
    logic [OUT_BITS-1:0]    ncount_reg;
    logic [CFG_BITS-1:0]    thr_reg;

    // vertex store
    logic [VERTEX_BITS-1:0] mem [VERTEX_DEPTH];
    logic [VERTEX_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic [VERTEX_BITS-1:0] va_reg, vb_reg, vc_reg;

    logic signed [EDGE_W-1:0]  u_reg [3];
    logic signed [EDGE_W-1:0]  v_reg [3];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic                      degen_reg;

    logic [RAD_W-1:0]  rad_reg;
    logic [SREM_W-1:0] srem_reg, srem_n, trial;
    logic [ROOT_W-1:0] root_reg;

    logic [DREM_W-1:0] drem_reg [3];
    logic [Q_W-1:0]    dlow_reg [3];
    logic [Q_W-1:0]    q_reg [3];

    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [OUT_BITS-1:0] nx_reg, ny_reg, nz_reg, idx_reg;

    logic store_write;
    logic [STEP_W-1:0] acc_k;

    assign store_write = cmd.emit && (cmd.kind == ST_STORED);
    assign acc_k       = cmd.step - 1'b1;

    // status back to the controller
    assign sts.is_face    = cmd_reg;
    assign sts.in_range   = (ia_reg < CMPW'(vcount_reg)) && (ib_reg < CMPW'(vcount_reg))
                            && (ic_reg < CMPW'(vcount_reg));
    assign sts.store_full = (vcount_reg == VC_W'(VERTEX_DEPTH));
    assign sts.degenerate = (sum_reg <= SUM_W'(thr_reg));
    assign sts.out_free   = !out_valid_reg || out_ready;

    // configuration and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= MIN_LEN_SQ_RESET;
            vcount_reg <= '0;
            ncount_reg <= '0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (store_write) begin
                vcount_reg <= vcount_reg + 1'b1;
            end
            if (cmd.emit && (cmd.kind == ST_NORMAL)) begin
                ncount_reg <= ncount_reg + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= in_command;
            vin_reg <= in_vertex;
            ia_reg  <= CMPW'(in_a);
            ib_reg  <= CMPW'(in_b);
            ic_reg  <= CMPW'(in_c);
        end
    end

    // read address select
    always_comb begin
        case (cmd.rd_sel)
            RD_B:    rd_addr = ib_reg[AW-1:0];
            RD_C:    rd_addr = ic_reg[AW-1:0];
            default: rd_addr = ia_reg[AW-1:0];
        endcase
    end

    // vertex memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (store_write) begin
            mem[vcount_reg[AW-1:0]] <= vin_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // corner vertices and edges
    always_ff @(posedge aclk) begin
        if (cmd.ld_va) va_reg <= rd_data_reg;
        if (cmd.ld_vb) vb_reg <= rd_data_reg;
        if (cmd.ld_vc) vc_reg <= rd_data_reg;
        if (cmd.edges) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= EDGE_W'($signed(vb_reg[i*COORD_BITS +: COORD_BITS]))
                          - EDGE_W'($signed(va_reg[i*COORD_BITS +: COORD_BITS]));
                v_reg[i] <= EDGE_W'($signed(vc_reg[i*COORD_BITS +: COORD_BITS]))
                          - EDGE_W'($signed(va_reg[i*COORD_BITS +: COORD_BITS]));
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_issue) begin
            mul_a = $signed({1'b0, mag_reg[cmd.step[1:0]]});
            mul_b = mul_a;
        end else if (cmd.mul_issue) begin
            case (cmd.step[2:0])
                3'd0: begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[2]); end
                3'd1: begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[1]); end
                3'd2: begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[0]); end
                3'd3: begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[2]); end
                3'd4: begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[1]); end
                3'd5: begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // product register, cross product and squared length
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.mul_acc) begin
            if (acc_k[0]) begin
                n_reg[acc_k[2:1]] <= n_reg[acc_k[2:1]] - CROSS_W'(prod_reg);
            end else begin
                n_reg[acc_k[2:1]] <= CROSS_W'(prod_reg);
            end
        end
        if (cmd.take_abs) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= n_reg[i][CROSS_W-1];
                mag_reg[i] <= n_reg[i][CROSS_W-1] ? MAG_W'(-n_reg[i]) : MAG_W'(n_reg[i]);
            end
            sum_reg <= '0;
        end
        if (cmd.sq_acc) begin
            sum_reg <= sum_reg + SUM_W'($unsigned(prod_reg));
        end
        if (cmd.degen_chk) begin
            degen_reg <= sts.degenerate;
        end
    end

    // square root, two radicand bits a step
    assign srem_n = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.degen_chk) begin
            rad_reg  <= RAD_W'(sum_reg) << FRAC_SHIFT;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= rad_reg << 2;
            if (srem_n >= trial) begin
                srem_reg <= srem_n - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= srem_n;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // divider lanes, one quotient bit a step
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            logic [NUM_W-1:0]  num;
            logic [DREM_W-1:0] rn;
            num = {1'b0, mag_reg[i], {FRAC_SHIFT{1'b0}}} + NUM_W'(root_reg >> 1);
            rn  = {drem_reg[i][DREM_W-2:0], dlow_reg[i][Q_W-1]};
            if (cmd.div_init) begin
                drem_reg[i] <= DREM_W'(num[NUM_W-1:Q_W]);
                dlow_reg[i] <= num[Q_W-1:0];
                q_reg[i]    <= '0;
            end else if (cmd.div_step) begin
                dlow_reg[i] <= dlow_reg[i] << 1;
                if (rn >= {1'b0, root_reg}) begin
                    drem_reg[i] <= rn - {1'b0, root_reg};
                    q_reg[i]    <= {q_reg[i][Q_W-2:0], 1'b1};
                end else begin
                    drem_reg[i] <= rn;
                    q_reg[i]    <= {q_reg[i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // clamp and sign of one lane
    function automatic logic [OUT_BITS-1:0] lane_out(input logic [Q_W-1:0] q, input logic neg);
        logic [OUT_BITS-1:0] m;
        m = (q > Q_W'(UNIT_Q14)) ? UNIT_Q14 : q[OUT_BITS-1:0];
        return neg ? (~m + 1'b1) : m;
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_reg <= cmd.kind;
            nx_reg     <= '0;
            ny_reg     <= '0;
            nz_reg     <= '0;
            idx_reg    <= '0;
            if (cmd.kind == ST_NORMAL) begin
                idx_reg <= ncount_reg;
                if (degen_reg) begin
                    nz_reg <= UNIT_Q14;
                end else begin
                    nx_reg <= lane_out(q_reg[0], neg_reg[0]);
                    ny_reg <= lane_out(q_reg[1], neg_reg[1]);
                    nz_reg <= lane_out(q_reg[2], neg_reg[2]);
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_nx     = nx_reg;
    assign out_ny     = ny_reg;
    assign out_nz     = nz_reg;
    assign out_index  = idx_reg;

endmodule

// ===== hw/rtl/tfn_checker.sv =====
// tfn_checker: port-level checks of the triangle flat normal unit
// depends on tfn_pkg; bound to triangle_flat_normal_unit below

module tfn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import tfn_pkg::*;

    // a result held back stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // only normals carry payload
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_NORMAL) |-> (m_tdata == 64'd0))
        else $error("non-normal result with payload");

    // components stay within unit magnitude
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NORMAL) |->
            ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384)
            && ($signed(m_tdata[31:16]) <= 16'sd16384)
            && ($signed(m_tdata[31:16]) >= -16'sd16384)
            && ($signed(m_tdata[47:32]) <= 16'sd16384)
            && ($signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("normal component out of range");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a taken request cannot produce a result on the next edge
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind triangle_flat_normal_unit tfn_checker u_tfn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
